// ===== rtl/fdkr_pkg.sv =====
// ----------------------------------------------------------------------------
// fdkr_pkg
// shared types and constants of the duplicate-reject queue
// ----------------------------------------------------------------------------
package fdkr_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned KeyW              = 32;
  localparam int unsigned DataW             = 32;
  localparam int unsigned StatusW           = 3;
  localparam int unsigned OccW              = 5;

  typedef enum logic [StatusW-1:0] {
    ST_ENQUEUED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_DEQUEUED  = 3'd3,
    ST_EMPTY     = 3'd4
  } status_e;

  typedef enum logic {
    OP_ENQUEUE = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_e;

  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctrl_t;

endpackage

// ===== rtl/fdkr_req_if.sv =====
// ----------------------------------------------------------------------------
// fdkr_req_if
// request channel: operation, key and payload with valid/ready
// ----------------------------------------------------------------------------
interface fdkr_req_if
  import fdkr_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic                    op;
  logic signed [KeyW-1:0]  key;
  logic signed [DataW-1:0] payload;

  modport source (output valid, output op, output key, output payload, input ready);
  modport sink   (input valid, input op, input key, input payload, output ready);
endinterface

// ===== rtl/fdkr_rsp_if.sv =====
// ----------------------------------------------------------------------------
// fdkr_rsp_if
// result channel: status, dequeued pair and occupancy with valid/ready
// ----------------------------------------------------------------------------
interface fdkr_rsp_if
  import fdkr_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [StatusW-1:0]      status;
  logic signed [KeyW-1:0]  out_key;
  logic signed [DataW-1:0] out_payload;
  logic [OccW-1:0]         occupancy;

  modport source (output valid, output status, output out_key, output out_payload,
                  output occupancy, input ready);
  modport sink   (input valid, input status, input out_key, input out_payload,
                  input occupancy, output ready);
endinterface

// ===== rtl/fdkr_cell.sv =====
// ----------------------------------------------------------------------------
// fdkr_cell
// one queue slot: holds a pair, compares its key, shifts toward the head
// ----------------------------------------------------------------------------
module fdkr_cell
  import fdkr_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cell_ctrl_t       ctrl_i,
  input  logic             nb_valid_i,
  input  logic [KeyW-1:0]  nb_key_i,
  input  logic [DataW-1:0] nb_data_i,
  input  logic [KeyW-1:0]  new_key_i,
  input  logic [DataW-1:0] new_data_i,
  output logic             valid_o,
  output logic [KeyW-1:0]  key_o,
  output logic [DataW-1:0] data_o,
  output logic             match_o
);

  logic             valid_q, valid_d;
  logic [KeyW-1:0]  key_q, key_d;
  logic [DataW-1:0] data_q, data_d;

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    data_d  = data_q;
    if (ctrl_i.shift) begin
      valid_d = nb_valid_i;
      key_d   = nb_key_i;
      data_d  = nb_data_i;
    end else if (ctrl_i.load) begin
      valid_d = 1'b1;
      key_d   = new_key_i;
      data_d  = new_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign key_o   = key_q;
  assign data_o  = data_q;
  assign match_o = valid_q && (key_q == new_key_i);

endmodule

// ===== rtl/fifo_with_duplicate_key_reject.sv =====
// ----------------------------------------------------------------------------
// fifo_with_duplicate_key_reject
// first-in first-out queue of key/payload pairs that refuses duplicate keys
// ----------------------------------------------------------------------------
// The queue is a row of QUEUE_DEPTH slot cells with the oldest entry in the
// first cell. An enqueue request is compared against the key of every held
// entry in the same cycle and is refused with a duplicate status on a match,
// or with a full status when all slots are taken; otherwise it is written
// into the first free cell. A dequeue returns the first cell and every cell
// takes its neighbor's contents, or reports empty. One request is taken per
// clock cycle; its result appears in the output register on the next cycle,
// and a new request is taken while that result waits as long as the sink
// takes it in the same cycle. The combinational key compare across all cells
// and the one-step shift of the cell row set this rate. Occupancy reports the
// entry count after the step, truncated or zero-extended to five bits.
module fifo_with_duplicate_key_reject
  import fdkr_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fdkr_req_if.sink   req_i,
  fdkr_rsp_if.source rsp_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);

  logic [CntW-1:0] count_q, count_d;

  logic             cell_valid [QUEUE_DEPTH+1];
  logic [KeyW-1:0]  cell_key   [QUEUE_DEPTH+1];
  logic [DataW-1:0] cell_data  [QUEUE_DEPTH+1];
  logic [QUEUE_DEPTH-1:0] match_vec;

  logic            fire, any_match, is_full, is_empty, enq_ok, deq_ok;
  status_e         status_d;
  logic [OccW-1:0] occ_d;

  logic                    rsp_valid_q;
  logic [StatusW-1:0]      status_q;
  logic signed [KeyW-1:0]  out_key_q;
  logic signed [DataW-1:0] out_payload_q;
  logic [OccW-1:0]         occ_q;

  assign req_i.ready = !rsp_valid_q || rsp_o.ready;
  assign fire        = req_i.valid && req_i.ready;

  assign any_match = |match_vec;
  assign is_full   = (count_q == CntW'(QUEUE_DEPTH));
  assign is_empty  = (count_q == '0);
  assign enq_ok    = fire && (req_i.op == OP_ENQUEUE) && !any_match && !is_full;
  assign deq_ok    = fire && (req_i.op == OP_DEQUEUE) && !is_empty;

  // tail of the row feeds an empty slot on shift
  assign cell_valid[QUEUE_DEPTH] = 1'b0;
  assign cell_key[QUEUE_DEPTH]   = '0;
  assign cell_data[QUEUE_DEPTH]  = '0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t ctrl;
    assign ctrl.shift = deq_ok;
    assign ctrl.load  = enq_ok && (count_q == CntW'(i));

    fdkr_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .nb_valid_i (cell_valid[i+1]),
      .nb_key_i   (cell_key[i+1]),
      .nb_data_i  (cell_data[i+1]),
      .new_key_i  (req_i.key),
      .new_data_i (req_i.payload),
      .valid_o    (cell_valid[i]),
      .key_o      (cell_key[i]),
      .data_o     (cell_data[i]),
      .match_o    (match_vec[i])
    );
  end

  always_comb begin
    count_d = count_q;
    if (enq_ok) begin
      count_d = count_q + CntW'(1);
    end else if (deq_ok) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_comb begin
    if (req_i.op == OP_ENQUEUE) begin
      if (any_match) begin
        status_d = ST_DUPLICATE;
      end else if (is_full) begin
        status_d = ST_FULL;
      end else begin
        status_d = ST_ENQUEUED;
      end
    end else begin
      status_d = is_empty ? ST_EMPTY : ST_DEQUEUED;
    end
  end

  if (CntW >= OccW) begin : g_occ_trunc
    assign occ_d = count_d[OccW-1:0];
  end else begin : g_occ_ext
    assign occ_d = {{(OccW-CntW){1'b0}}, count_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (fire) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      status_q      <= status_d;
      out_key_q     <= deq_ok ? cell_key[0] : '0;
      out_payload_q <= deq_ok ? cell_data[0] : '0;
      occ_q         <= occ_d;
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = status_q;
  assign rsp_o.out_key     = out_key_q;
  assign rsp_o.out_payload = out_payload_q;
  assign rsp_o.occupancy   = occ_q;

endmodule
